[hw/rtl/assert_macros.svh]
// assertion macros used by the port-level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is asserted
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  `ASSERT_CLK(name, clk, rst_n, !(cond), msg)

`endif

[hw/rtl/pcpr_pkg.sv]
// shared types and constants of the packet resequencer
// no dependencies
`default_nettype none

package pcpr_pkg;

  localparam int CH_W              = 5;
  localparam int EV_W              = 31;
  localparam int HANDLE_W          = 16;
  localparam int CFG_W             = 32;
  // pending depth is at most 32, so a slot offset fits five bits
  localparam int REM_W             = 5;
  localparam int DEF_CHANNELS      = 32;
  localparam int DEF_PENDING_DEPTH = 8;
  localparam int QUEUE_DEPTH       = 2;

  typedef enum logic {
    REL_IN_ORDER = 1'b0,
    REL_LOSS     = 1'b1
  } release_kind_e;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [EV_W-1:0]     event_number;
    logic [HANDLE_W-1:0] buffer_handle;
  } req_t;

  typedef struct packed {
    logic [CH_W-1:0]     out_channel;
    logic [EV_W-1:0]     out_event;
    logic [HANDLE_W-1:0] out_handle;
    release_kind_e       release_kind;
    logic                last_of_run;
  } res_t;

  // request plus its slot offset (event mod pending depth)
  typedef struct packed {
    req_t             req;
    logic [REM_W-1:0] rem;
  } entry_t;

endpackage

`default_nettype wire

[hw/rtl/pcpr_ram.sv]
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module pcpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/pcpr_front.sv]
// front end: enable register, request filter and byte-serial slot offset unit
// depends on pcpr_pkg
`default_nettype none

module pcpr_front #(
  parameter int CHANNELS      = pcpr_pkg::DEF_CHANNELS,
  parameter int PENDING_DEPTH = pcpr_pkg::DEF_PENDING_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pcpr_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                         take_i,
  input  pcpr_pkg::req_t               req_i,
  input  logic                         full_i,
  output logic                         busy_o,
  output logic                         push_o,
  output pcpr_pkg::entry_t             entry_o
);

  import pcpr_pkg::*;

  localparam int ByteW = 8;
  localparam int RestW = EV_W - (ByteW - 1);
  localparam int Steps = RestW / ByteW;
  localparam int CntW  = $clog2(Steps + 1);
  localparam int VW    = REM_W + 1;

  // one byte of the remainder, msb first, one compare-subtract per bit
  function automatic logic [REM_W-1:0] rem_step(input logic [REM_W-1:0] r,
                                                input logic [ByteW-1:0] b);
    logic [VW-1:0]    v;
    logic [REM_W-1:0] acc;
    acc = r;
    for (int i = ByteW - 1; i >= 0; i--) begin
      v = {acc, b[i]};
      if (v >= VW'(PENDING_DEPTH)) begin
        v = v - VW'(PENDING_DEPTH);
      end
      acc = v[REM_W-1:0];
    end
    return acc;
  endfunction

  logic [CFG_W-1:0] enable_q;
  logic             act_q;
  logic [CntW-1:0]  cnt_q;
  req_t             req_q;
  logic [RestW-1:0] rest_q;
  logic [REM_W-1:0] rem_q;
  logic             keep;
  logic             done;

  assign keep    = (int'(req_i.channel) < CHANNELS) && enable_q[req_i.channel];
  assign done    = act_q && (cnt_q == CntW'(Steps));
  assign push_o  = done && !full_i;
  assign busy_o  = act_q && !push_o;
  assign entry_o = '{req: req_q, rem: rem_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      act_q    <= 1'b0;
      cnt_q    <= '0;
      req_q    <= '0;
      rest_q   <= '0;
      rem_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      // disabled or out-of-range channels are taken and dropped here
      if (take_i && keep) begin
        act_q  <= 1'b1;
        cnt_q  <= '0;
        req_q  <= req_i;
        rem_q  <= rem_step('0, ByteW'(req_i.event_number[EV_W-1:RestW]));
        rest_q <= req_i.event_number[RestW-1:0];
      end else if (push_o) begin
        act_q <= 1'b0;
      end else if (act_q && !done) begin
        rem_q  <= rem_step(rem_q, rest_q[RestW-1 -: ByteW]);
        rest_q <= rest_q << ByteW;
        cnt_q  <= cnt_q + CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pcpr_queue.sv]
// short request queue between front end and back end
// depends on pcpr_pkg
`default_nettype none

module pcpr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pcpr_pkg::entry_t entry_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic             full_o,
  output pcpr_pkg::entry_t head_o
);

  import pcpr_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  entry_t          mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pcpr_back.sv]
// back end: last-event and slot stores, release and drain sequencer
// depends on pcpr_pkg and pcpr_ram
`default_nettype none

module pcpr_back #(
  parameter int CHANNELS      = pcpr_pkg::DEF_CHANNELS,
  parameter int PENDING_DEPTH = pcpr_pkg::DEF_PENDING_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  pcpr_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             clearing_o,
  output logic             res_valid_o,
  output pcpr_pkg::res_t   res_o
);

  import pcpr_pkg::*;

  localparam int Slots = CHANNELS * PENDING_DEPTH;
  localparam int SlotW = $clog2(Slots);
  localparam int ChW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int KW    = $clog2(PENDING_DEPTH);

  typedef struct packed {
    logic                valid;
    logic [EV_W-1:0]     ev;
    logic [HANDLE_W-1:0] handle;
  } slot_t;

  localparam int SlotDW = $bits(slot_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DRAIN
  } state_e;

  // offset of the event after e; the 31-bit wrap to zero restarts at offset zero
  function automatic logic [REM_W-1:0] nrem(input logic [REM_W-1:0] r,
                                            input logic [EV_W-1:0] e);
    return ((e == '1) || (r == REM_W'(PENDING_DEPTH - 1))) ? '0 : r + REM_W'(1);
  endfunction

  function automatic logic [SlotW-1:0] base_of(input logic [CH_W-1:0] ch);
    return SlotW'(ch) * SlotW'(PENDING_DEPTH);
  endfunction

  state_e              state_q;
  logic                clr_q;
  logic [SlotW-1:0]    clr_cnt_q;
  logic [CH_W-1:0]     ch_q;
  logic [EV_W-1:0]     ev_q;
  logic [HANDLE_W-1:0] h_q;
  logic [SlotW-1:0]    base_q;
  logic [EV_W-1:0]     cur_q;
  logic [REM_W-1:0]    cur_rem_q;
  logic [KW-1:0]       kk_q;
  logic [EV_W-1:0]     last_q;
  res_t                hold_q;
  res_t                res_q;
  logic                res_valid_q;

  slot_t               slot_rd;
  logic [SlotDW-1:0]   slot_rdata;
  logic [EV_W-1:0]     last_rd;
  logic                slot_we;
  logic [SlotW-1:0]    slot_waddr;
  slot_t               slot_wdata;
  logic [SlotW-1:0]    slot_raddr;
  logic                last_we;
  logic [ChW-1:0]      last_waddr;
  logic [EV_W-1:0]     last_wdata;
  logic [ChW-1:0]      last_raddr;

  logic [REM_W-1:0]    rem1;
  logic [EV_W-1:0]     want;
  logic                more;
  logic                newer;
  logic                loss;
  logic [EV_W-1:0]     last2;
  logic                overtaken;
  logic                follow;
  logic [SlotW-1:0]    own_addr;
  res_t                loss_res;

  assign slot_rd   = slot_t'(slot_rdata);
  assign rem1      = nrem(cur_rem_q, cur_q);
  assign want      = cur_q + EV_W'(1);
  assign more      = slot_rd.valid && (slot_rd.ev == want) &&
                     (kk_q < KW'(PENDING_DEPTH - 1));
  assign newer     = ev_q > last_rd;
  assign loss      = slot_rd.valid;
  // last released never moves backward
  assign last2     = (loss && (slot_rd.ev > last_rd)) ? slot_rd.ev : last_rd;
  assign overtaken = ev_q <= last2;
  assign follow    = (last2 == '0) || (ev_q == last2 + EV_W'(1));
  assign own_addr  = base_q + SlotW'(cur_rem_q);
  assign loss_res  = '{out_channel:  ch_q,
                       out_event:    slot_rd.ev,
                       out_handle:   slot_rd.handle,
                       release_kind: REL_LOSS,
                       last_of_run:  overtaken || !follow};

  assign pop_o      = (state_q == ST_IDLE) && !clr_q && valid_i;
  assign last_raddr = ChW'(head_i.req.channel);
  assign clearing_o = clr_q;

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = own_addr;
    slot_wdata = '0;
    slot_raddr = '0;
    last_we    = 1'b0;
    last_waddr = ChW'(ch_q);
    last_wdata = last2;
    unique case (state_q)
      ST_IDLE: begin
        slot_raddr = base_of(head_i.req.channel) + SlotW'(head_i.rem);
      end
      ST_EVAL: begin
        // first drain lookup goes out while the own slot is resolved
        slot_raddr = base_q + SlotW'(rem1);
        if (newer) begin
          if (loss && overtaken) begin
            slot_we = 1'b1;
            last_we = 1'b1;
          end else if (follow) begin
            slot_we = loss;
          end else begin
            slot_we    = 1'b1;
            slot_wdata = '{valid: 1'b1, ev: ev_q, handle: h_q};
            last_we    = loss;
          end
        end
      end
      ST_DRAIN: begin
        slot_raddr = base_q + SlotW'(nrem(rem1, want));
        if (more) begin
          slot_we    = 1'b1;
          slot_waddr = base_q + SlotW'(rem1);
        end else begin
          last_we    = 1'b1;
          last_wdata = last_q;
        end
      end
      default: begin
        slot_raddr = '0;
      end
    endcase
    // sweep after reset
    if (clr_q) begin
      slot_we    = 1'b1;
      slot_waddr = clr_cnt_q;
      slot_wdata = '0;
      last_we    = 1'b1;
      last_waddr = clr_cnt_q[ChW-1:0];
      last_wdata = '0;
    end
  end

  pcpr_ram #(
    .WIDTH (SlotDW),
    .DEPTH (Slots)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  pcpr_ram #(
    .WIDTH (EV_W),
    .DEPTH (CHANNELS)
  ) u_last_ram (
    .clk_i   (clk_i),
    .we_i    (last_we),
    .waddr_i (last_waddr),
    .wdata_i (last_wdata),
    .raddr_i (last_raddr),
    .rdata_o (last_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      ch_q        <= '0;
      ev_q        <= '0;
      h_q         <= '0;
      base_q      <= '0;
      cur_q       <= '0;
      cur_rem_q   <= '0;
      kk_q        <= '0;
      last_q      <= '0;
      hold_q      <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + SlotW'(1);
        if (clr_cnt_q == SlotW'(Slots - 1)) begin
          clr_q <= 1'b0;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            ch_q      <= head_i.req.channel;
            ev_q      <= head_i.req.event_number;
            h_q       <= head_i.req.buffer_handle;
            base_q    <= base_of(head_i.req.channel);
            cur_q     <= head_i.req.event_number;
            cur_rem_q <= head_i.rem;
            state_q   <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state_q <= ST_IDLE;
          if (newer) begin
            if (loss) begin
              res_q       <= loss_res;
              res_valid_q <= 1'b1;
            end
            if (!overtaken && follow) begin
              hold_q  <= '{out_channel:  ch_q,
                           out_event:    ev_q,
                           out_handle:   h_q,
                           release_kind: REL_IN_ORDER,
                           last_of_run:  1'b0};
              last_q  <= ev_q;
              kk_q    <= '0;
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          // held release goes out once the next lookup tells if it ends the run
          res_q             <= hold_q;
          res_q.last_of_run <= !more;
          res_valid_q       <= 1'b1;
          if (more) begin
            hold_q    <= '{out_channel:  ch_q,
                           out_event:    want,
                           out_handle:   slot_rd.handle,
                           release_kind: REL_IN_ORDER,
                           last_of_run:  1'b0};
            cur_q     <= want;
            cur_rem_q <= rem1;
            last_q    <= want;
            kk_q      <= kk_q + KW'(1);
          end else begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

[hw/rtl/per_channel_packet_resequencer.sv]
// top level of the per-channel packet resequencer
// depends on pcpr_pkg, pcpr_front, pcpr_queue and pcpr_back
//
//   port group      direction  handshake              payload
//   request         in         start / busy           item_i (req_t)
//   result          out        res_valid_o strobe     res_o (res_t)
//   channel enable  in         cfg_we_i               cfg_wdata_i
//
// the front end takes a new request once its byte-serial event mod PENDING_DEPTH
// unit has pushed the last one; disabled channels are dropped at once
// the back end takes each request through ST_IDLE and ST_EVAL, and through ST_DRAIN
// when it is released in order, where the parked packets that follow it are drained
// with one result per cycle on the slot ram read port; after reset busy stays high
// while the slot and last-event stores are swept
// results are never held back; a full queue keeps busy high on a finished request
`default_nettype none

module per_channel_packet_resequencer #(
  parameter int CHANNELS      = pcpr_pkg::DEF_CHANNELS,
  parameter int PENDING_DEPTH = pcpr_pkg::DEF_PENDING_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  pcpr_pkg::req_t             item_i,
  input  logic                       cfg_we_i,
  input  logic [pcpr_pkg::CFG_W-1:0] cfg_wdata_i,
  output logic                       res_valid_o,
  output pcpr_pkg::res_t             res_o
);

  import pcpr_pkg::*;

  logic   front_busy;
  logic   clearing;
  logic   take;
  logic   push;
  entry_t push_entry;
  logic   q_valid;
  logic   q_full;
  entry_t q_head;
  logic   pop;

  assign busy = front_busy || clearing;
  assign take = start && !busy;

  pcpr_front #(
    .CHANNELS      (CHANNELS),
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .req_i       (item_i),
    .full_i      (q_full),
    .busy_o      (front_busy),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  pcpr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .head_o  (q_head)
  );

  pcpr_back #(
    .CHANNELS      (CHANNELS),
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .head_i      (q_head),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

[hw/rtl/pcpr_checker.sv]
// port-level checks of the packet resequencer, bound to the top level
// depends on pcpr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pcpr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input pcpr_pkg::req_t             item_i,
  input logic                       cfg_we_i,
  input logic [pcpr_pkg::CFG_W-1:0] cfg_wdata_i,
  input logic                       res_valid_o,
  input pcpr_pkg::res_t             res_o
);

  import pcpr_pkg::*;

  // store sweep keeps requests out right after reset
  `ASSERT_CLK(a_busy_after_reset, clk_i, rst_ni, $rose(rst_ni) |-> busy, "no sweep after reset")

  // event zero is always stale, so it is never released
  `ASSERT_NEVER(a_no_event_zero, clk_i, rst_ni, res_valid_o && (res_o.out_event == '0), "event zero released")

  // a run is released in back-to-back cycles on one channel
  `ASSERT_CLK(a_run_contiguous, clk_i, rst_ni, res_valid_o && !res_o.last_of_run |=> res_valid_o && (res_o.out_channel == $past(res_o.out_channel)), "run broken")

  // an in-order release is followed in its run by the next event
  `ASSERT_CLK(a_run_consecutive, clk_i, rst_ni, res_valid_o && !res_o.last_of_run && (res_o.release_kind == REL_IN_ORDER) |=> (res_o.out_event == $past(res_o.out_event) + 31'd1) && (res_o.release_kind == REL_IN_ORDER), "drain out of sequence")

endmodule

bind per_channel_packet_resequencer pcpr_checker u_checker (.*);

`default_nettype wire

[bench/pcpr_checker.sv]
// release predictor and scoreboard for the packet resequencer bench
// watches the request, result and channel-enable ports; depends on pcpr_pkg
module pcpr_scoreboard
  import pcpr_pkg::*;
#(
  parameter int CHANNELS      = DEF_CHANNELS,
  parameter int PENDING_DEPTH = DEF_PENDING_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  req_t             req_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             res_valid_i,
  input  res_t             res_i,
  output int unsigned      mismatches_o,
  output int unsigned      outstanding_o
);

  localparam int          SLOTS   = CHANNELS * PENDING_DEPTH;
  localparam int unsigned EV_MASK = (32'd1 << EV_W) - 1;

  logic [CFG_W-1:0]    enable_q;
  logic [EV_W-1:0]     last_rel [CHANNELS];
  logic                slot_vld [SLOTS];
  logic [EV_W-1:0]     slot_ev  [SLOTS];
  logic [HANDLE_W-1:0] slot_hdl [SLOTS];
  res_t                release_q[$];
  int unsigned         mismatch_cnt;

  function automatic res_t released(int unsigned ch, int unsigned ev, int unsigned hdl,
                                    release_kind_e kind);
    res_t x;
    x.out_channel  = CH_W'(ch);
    x.out_event    = EV_W'(ev);
    x.out_handle   = HANDLE_W'(hdl);
    x.release_kind = kind;
    x.last_of_run  = 1'b0;
    return x;
  endfunction

  // works out the releases one request causes and queues them in order
  task automatic resequence(input req_t r);
    int unsigned ch, ev, last, base, s, t, want;
    bit          overtaken;
    res_t        run[$];
    res_t        one;
    ch        = r.channel;
    ev        = r.event_number;
    overtaken = 1'b0;
    if (ch >= CHANNELS || !enable_q[ch]) return;
    last = last_rel[ch];
    if (ev <= last) return;
    base = ch * PENDING_DEPTH;
    s    = base + ev % PENDING_DEPTH;
    // occupied slot: parked packet goes out as a loss first
    if (slot_vld[s]) begin
      slot_vld[s] = 1'b0;
      run.push_back(released(ch, slot_ev[s], slot_hdl[s], REL_LOSS));
      if (slot_ev[s] > last) last = slot_ev[s];
      last_rel[ch] = EV_W'(last);
      overtaken = (ev <= last);
    end
    if (!overtaken) begin
      if (last == 0 || ev == last + 1) begin
        run.push_back(released(ch, ev, r.buffer_handle, REL_IN_ORDER));
        last = ev;
        for (int k = 1; k < PENDING_DEPTH; k++) begin
          want = (ev + k) & EV_MASK;
          t    = base + want % PENDING_DEPTH;
          if (!slot_vld[t] || slot_ev[t] != want) break;
          slot_vld[t] = 1'b0;
          run.push_back(released(ch, want, slot_hdl[t], REL_IN_ORDER));
          last = want;
        end
        last_rel[ch] = EV_W'(last);
      end else begin
        slot_vld[s] = 1'b1;
        slot_ev[s]  = EV_W'(ev);
        slot_hdl[s] = r.buffer_handle;
      end
    end
    for (int i = 0; i < run.size(); i++) begin
      one             = run[i];
      one.last_of_run = (i == run.size() - 1);
      release_q.push_back(one);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp;
    if (!rst_ni) begin
      enable_q = '0;
      for (int c = 0; c < CHANNELS; c++) last_rel[c] = '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_vld[i] = 1'b0;
        slot_ev[i]  = '0;
        slot_hdl[i] = '0;
      end
      release_q.delete();
      mismatch_cnt  = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      // a result never belongs to a request taken at the same edge
      if (res_valid_i) begin
        if (release_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: release with none expected: ch %0d ev %0d handle %h kind %0d last %0b",
                     $time, res_i.out_channel, res_i.out_event, res_i.out_handle,
                     res_i.release_kind, res_i.last_of_run);
          mismatch_cnt++;
        end else begin
          exp = release_q.pop_front();
          if (res_i.out_channel !== exp.out_channel || res_i.out_event !== exp.out_event ||
              res_i.out_handle !== exp.out_handle || res_i.release_kind !== exp.release_kind ||
              res_i.last_of_run !== exp.last_of_run) begin
            if (mismatch_cnt < 10)
              $display("%0t: release mismatch: got ch %0d ev %0d handle %h kind %0d last %0b, %s",
                       $time, res_i.out_channel, res_i.out_event, res_i.out_handle,
                       res_i.release_kind, res_i.last_of_run,
                       $sformatf("expected ch %0d ev %0d handle %h kind %0d last %0b",
                                 exp.out_channel, exp.out_event, exp.out_handle,
                                 exp.release_kind, exp.last_of_run));
            mismatch_cnt++;
          end
        end
      end
      if (cfg_we_i) enable_q = cfg_wdata_i;
      if (start_i && !busy_i) resequence(req_i);
      mismatches_o  <= mismatch_cnt;
      outstanding_o <= release_q.size();
    end
  end

endmodule

[bench/tb_top.sv]
// top of the packet resequencer bench: clock, reset, requests and verdict
// depends on pcpr_pkg, per_channel_packet_resequencer and pcpr_scoreboard
module tb_top;
  import pcpr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          SETTLE      = 64;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  req_t             item      = '0;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             res_valid;
  res_t             res;
  int unsigned      mismatches;
  int unsigned      outstanding;

  int unsigned      cycle_cnt   = 0;
  int unsigned      handled_cnt = 0;
  int               idle_pct    = 0;
  logic [CFG_W-1:0] enable_mask = '0;
  logic [EV_W-1:0]  gen_next [32];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  per_channel_packet_resequencer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .item_i      (item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pcpr_scoreboard checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (item),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // start stays high between back-to-back requests
  task automatic send_req(input logic [CH_W-1:0] ch, input logic [EV_W-1:0] ev,
                          input logic [HANDLE_W-1:0] hdl);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= '{channel: ch, event_number: ev, buffer_handle: hdl};
    do @(posedge clk); while (busy);
    if (enable_mask[ch]) handled_cnt++;
  endtask

  task automatic write_enable(input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    enable_mask = v;
  endtask

  // wait for every release, then for requests that release nothing
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // a window of consecutive events, mostly shuffled, with some lost or repeated
  task automatic send_window(input logic [CH_W-1:0] ch);
    int unsigned     w, j, roll;
    logic [EV_W-1:0] evs[$];
    logic [EV_W-1:0] tmp;
    w = $urandom_range(10, 1);
    for (int i = 0; i < w; i++) evs.push_back(gen_next[ch] + EV_W'(i));
    if ($urandom_range(3, 0) != 0) begin
      for (int i = w - 1; i > 0; i--) begin
        j      = $urandom_range(i, 0);
        tmp    = evs[i];
        evs[i] = evs[j];
        evs[j] = tmp;
      end
    end
    foreach (evs[i]) begin
      roll = $urandom_range(99, 0);
      if (roll >= 8) send_req(ch, evs[i], HANDLE_W'($urandom));
      if (roll >= 95) send_req(ch, evs[i], HANDLE_W'($urandom));
    end
    gen_next[ch] += EV_W'(w);
    if ($urandom_range(9, 0) == 0) gen_next[ch] += EV_W'($urandom_range(30, 1));
  endtask

  task automatic send_noise();
    logic [CH_W-1:0] ch;
    logic [EV_W-1:0] ev;
    ch = CH_W'($urandom_range(31, 0));
    case ($urandom_range(2, 0))
      0:       ev = EV_W'($urandom);
      1:       ev = gen_next[ch] - EV_W'($urandom_range(5, 0));
      default: ev = gen_next[ch] + EV_W'($urandom_range(40, 0));
    endcase
    send_req(ch, ev, HANDLE_W'($urandom));
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned     goal;
    logic [CH_W-1:0] ch;
    goal = handled_cnt + n;
    while (handled_cnt < goal) begin
      if ($urandom_range(99, 0) < 85) begin
        do ch = CH_W'($urandom_range(31, 0)); while (!enable_mask[ch]);
        send_window(ch);
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // slot sweep after reset
    do @(posedge clk); while (busy);
    write_enable('1);
    idle_pct = 36;

    // zero on a fresh channel, first release, repeat, gaps, drain
    send_req(5'd0, 31'd0, 16'h1234);
    send_req(5'd0, 31'd1, 16'h0000);
    send_req(5'd0, 31'd1, 16'h0001);
    send_req(5'd0, 31'd3, 16'hffff);
    send_req(5'd0, 31'd4, 16'h0004);
    send_req(5'd0, 31'd2, 16'h0002);
    // occupied slot forces a loss, the new one parks behind it
    send_req(5'd0, 31'd13, 16'h000d);
    send_req(5'd0, 31'd21, 16'h0015);
    send_req(5'd0, 31'd14, 16'h000e);
    // loss release overtakes the new event
    send_req(5'd1, 31'd100, 16'haaaa);
    send_req(5'd1, 31'd105, 16'h5555);
    send_req(5'd1, 31'd113, 16'h0113);
    send_req(5'd1, 31'd113, 16'h0f13);
    // drain stops at a slot holding a later event
    send_req(5'd2, 31'd8, 16'h0008);
    send_req(5'd2, 31'd18, 16'h0012);
    send_req(5'd2, 31'd9, 16'h0009);
    // longest drain
    send_req(5'd3, 31'd1, 16'h0301);
    for (int e = 3; e <= 9; e++) send_req(5'd3, EV_W'(e), HANDLE_W'(16'h0300 + e));
    send_req(5'd3, 31'd2, 16'h0302);
    send_req(5'd31, 31'h7fff_ffff, 16'hffff);

    for (int c = 0; c < 32; c++) begin
      case ($urandom_range(9, 0))
        0:       gen_next[c] = EV_W'($urandom);
        1:       gen_next[c] = 31'h7fff_ffff - EV_W'($urandom_range(12, 0));
        default: gen_next[c] = EV_W'($urandom_range(40, 1));
      endcase
    end
    run_random(135);

    settle();
    write_enable($urandom | 32'h1);
    idle_pct = 75;
    run_random(135);

    settle();
    write_enable('0);
    repeat (20) send_noise();

    settle();
    write_enable($urandom | (32'h1 << $urandom_range(31, 0)));
    idle_pct = 0;
    run_random(135);

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/pcpr_pkg.sv
hw/rtl/pcpr_ram.sv
hw/rtl/pcpr_front.sv
hw/rtl/pcpr_queue.sv
hw/rtl/pcpr_back.sv
hw/rtl/per_channel_packet_resequencer.sv
hw/rtl/pcpr_checker.sv
bench/pcpr_checker.sv
bench/tb_top.sv
